>>> hdl/tip_pkg.sv
`default_nettype none

package tip_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int COUNT_WIDTH_DEF = 8;

	localparam int CHAR_W   = 8;
	localparam int NUMBER_W = 32;
	localparam int CONSUMED_W = 8;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	localparam logic [1:0] REG_START_DECIMAL   = 2'd0;
	localparam logic [1:0] REG_TRIM_LEADING    = 2'd1;
	localparam logic [1:0] REG_ACCEPT_NEGATIVE = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_LOW_X = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOW_F = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;

	typedef struct packed {
		logic start_decimal;
		logic trim_leading;
		logic accept_negative;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{start_decimal: 1'b1, trim_leading: 1'b0,
		accept_negative: 1'b0};

endpackage

`default_nettype wire

>>> hdl/text_integer_parser_core.sv
`default_nettype none

// Channel   Handshake                  Payload
// text      text_valid / text_stall    text_char
// number    number_valid / number_stall number_value, number_found, chars_consumed,
//                                       stop_char
// config    APB psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One character word is accepted per cycle while text_stall is low; the character that
// ends the number passes the single input register and the parse stage, whose
// multiply-add is combinational, and the result is held in the output register. Reset
// restores the register defaults and an empty number. A stalled result holds the output
// register, which backs up into the input register and then into text_stall.

module text_integer_parser_core
	import tip_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [APB_ADDR_W-1:0]  paddr,
	input  wire logic [APB_DATA_W-1:0]  pwdata,
	output logic      [APB_DATA_W-1:0]  prdata,
	output logic                        pready,
	input  wire logic                   text_valid,
	output logic                        text_stall,
	input  wire logic [CHAR_W-1:0]      text_char,
	output logic                        number_valid,
	input  wire logic                   number_stall,
	output logic signed [NUMBER_W-1:0]  number_value,
	output logic                        number_found,
	output logic [CONSUMED_W-1:0]       chars_consumed,
	output logic [CHAR_W-1:0]           stop_char
);

	cfg_t                   cfg, cfg_next;
	logic                   cfg_wr;
	logic                   valid_s1;
	logic [CHAR_W-1:0]      char_s1;
	logic                   adv, fire, emit;
	logic [VALUE_WIDTH-1:0] value;
	logic                   found;
	logic [COUNT_WIDTH-1:0] count;

	logic                   out_valid_q;
	logic [NUMBER_W-1:0]    value_q;
	logic                   found_q;
	logic [CONSUMED_W-1:0]  consumed_q;
	logic [CHAR_W-1:0]      stop_q;

	tip_apb_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg      (cfg),
		.cfg_next (cfg_next),
		.cfg_wr   (cfg_wr)
	);

	// The parse stage moves whenever the output register is free or being drained.
	assign adv        = !(out_valid_q && number_stall);
	assign fire       = valid_s1 && adv;
	assign text_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			char_s1 <= text_char;
		end
	end

	tip_parse #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_next (cfg_next),
		.cfg_wr   (cfg_wr),
		.fire     (fire),
		.ch       (char_s1),
		.emit     (emit),
		.value    (value),
		.found    (found),
		.count    (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			value_q    <= NUMBER_W'(value);
			found_q    <= found;
			consumed_q <= CONSUMED_W'(count);
			stop_q     <= char_s1;
		end
	end

	assign number_valid   = out_valid_q;
	assign number_value   = $signed(value_q);
	assign number_found   = found_q;
	assign chars_consumed = consumed_q;
	assign stop_char      = stop_q;

endmodule

`default_nettype wire

>>> hdl/tip_apb_regs.sv
`default_nettype none

module tip_apb_regs
	import tip_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg,
	output cfg_t                       cfg_next,
	output logic                       cfg_wr
);

	logic [1:0] reg_idx;
	logic       wr_en;
	cfg_t       cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	// Only the three defined registers restart the parser; other addresses are ignored.
	always_comb begin
		cfg_next = cfg_q;
		cfg_wr   = 1'b0;
		if (wr_en) begin
			case (reg_idx)
				REG_START_DECIMAL: begin
					cfg_next.start_decimal = pwdata[0];
					cfg_wr = 1'b1;
				end
				REG_TRIM_LEADING: begin
					cfg_next.trim_leading = pwdata[0];
					cfg_wr = 1'b1;
				end
				REG_ACCEPT_NEGATIVE: begin
					cfg_next.accept_negative = pwdata[0];
					cfg_wr = 1'b1;
				end
				default: begin
					cfg_wr = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else begin
			cfg_q <= cfg_next;
		end
	end

	always_comb begin
		case (reg_idx)
			REG_START_DECIMAL:   prdata = APB_DATA_W'(cfg_q.start_decimal);
			REG_TRIM_LEADING:    prdata = APB_DATA_W'(cfg_q.trim_leading);
			REG_ACCEPT_NEGATIVE: prdata = APB_DATA_W'(cfg_q.accept_negative);
			default:             prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hdl/tip_parse.sv
`default_nettype none

module tip_parse
	import tip_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cfg_t                   cfg,
	input  wire cfg_t                   cfg_next,
	input  wire logic                   cfg_wr,
	input  wire logic                   fire,
	input  wire logic [CHAR_W-1:0]      ch,
	output logic                        emit,
	output logic [VALUE_WIDTH-1:0]      value,
	output logic                        found,
	output logic [COUNT_WIDTH-1:0]      count
);

	localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic [VALUE_WIDTH-1:0] acc_q;
	logic                   hex_q;
	logic                   neg_q;
	logic                   found_q;
	logic                   trim_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	logic                   is_dec, is_lhex, is_uhex, d_ok;
	logic [3:0]             d_val;
	logic                   is_nul, is_minus, is_x, acc_zero;
	logic                   skip, take_x, take_minus, consume;
	logic                   hex_n;
	logic [3:0]             dig;
	logic [VALUE_WIDTH-1:0] acc_n;
	logic [COUNT_WIDTH-1:0] cnt_inc;

	always_comb begin
		is_dec  = (ch >= CH_ZERO) && (ch <= CH_NINE);
		is_lhex = hex_q && (ch >= CH_LOW_A) && (ch <= CH_LOW_F);
		is_uhex = hex_q && (ch >= CH_UP_A) && (ch <= CH_UP_F);
		d_ok    = is_dec || is_lhex || is_uhex;
		if (is_dec) begin
			d_val = 4'(ch - CH_ZERO);
		end else if (is_lhex) begin
			d_val = 4'(ch - CH_LOW_A + 8'd10);
		end else begin
			d_val = 4'(ch - CH_UP_A + 8'd10);
		end
	end

	assign is_nul   = (ch == CH_NUL);
	assign is_minus = (ch == CH_MINUS);
	assign is_x     = (ch == CH_LOW_X) || (ch == CH_UP_X);
	assign acc_zero = (acc_q == '0);

	// While trimming, anything but a digit, a minus or NUL is counted and dropped.
	assign skip       = trim_q && !is_nul && !d_ok && !is_minus;
	assign take_x     = !is_nul && !d_ok && acc_zero && is_x;
	assign take_minus = !is_nul && !d_ok && acc_zero && is_minus;
	assign consume    = !is_nul && (d_ok || take_x || take_minus);
	assign emit       = fire && !skip && !consume;

	assign hex_n   = hex_q || take_x;
	assign dig     = d_ok ? d_val : 4'd0;
	assign acc_n   = hex_n ? ((acc_q << 4) + VALUE_WIDTH'(dig))
	                       : ((acc_q << 3) + (acc_q << 1) + VALUE_WIDTH'(dig));
	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

	always_comb begin
		if (found_q) begin
			value = neg_q ? (VALUE_WIDTH'(0) - acc_q) : acc_q;
		end else begin
			value = cfg.accept_negative ? VAL_MIN : '1;
		end
	end

	assign found = found_q;
	assign count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			hex_q   <= !CFG_RESET.start_decimal;
			neg_q   <= 1'b0;
			found_q <= 1'b0;
			trim_q  <= CFG_RESET.trim_leading;
			cnt_q   <= '0;
		end else if (cfg_wr) begin
			acc_q   <= '0;
			hex_q   <= !cfg_next.start_decimal;
			neg_q   <= 1'b0;
			found_q <= 1'b0;
			trim_q  <= cfg_next.trim_leading;
			cnt_q   <= '0;
		end else if (fire) begin
			if (skip) begin
				cnt_q <= cnt_inc;
			end else if (consume) begin
				acc_q   <= acc_n;
				hex_q   <= hex_n;
				neg_q   <= neg_q || take_minus;
				found_q <= 1'b1;
				trim_q  <= 1'b0;
				cnt_q   <= cnt_inc;
			end else begin
				acc_q   <= '0;
				hex_q   <= !cfg.start_decimal;
				neg_q   <= 1'b0;
				found_q <= 1'b0;
				trim_q  <= cfg.trim_leading;
				cnt_q   <= '0;
			end
		end
	end

endmodule

`default_nettype wire
